// ----- rtl/core/cplc_pkg.sv -----
// Package for the log record classifier: request/result structs, request
// codes, failure codes and register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cplc_pkg;

    // Request type codes
    localparam logic [2:0] REQ_LOAD_SRC_PFX = 3'd0;
    localparam logic [2:0] REQ_LOAD_DST_PFX = 3'd1;
    localparam logic [2:0] REQ_LOAD_SRC_RNG = 3'd2;
    localparam logic [2:0] REQ_LOAD_DST_RNG = 3'd3;
    localparam logic [2:0] REQ_CLASSIFY     = 3'd4;

    // Protocol modes
    localparam logic [1:0] PROTO_ICMP = 2'd2;
    localparam logic [1:0] PROTO_RSVD = 2'd3;

    // Check enable bit positions
    localparam int EN_SRC_ADDR = 0;
    localparam int EN_SRC_PORT = 1;
    localparam int EN_DST_ADDR = 2;
    localparam int EN_DST_PORT = 3;
    localparam int EN_ACTION   = 4;
    localparam int EN_HOOK     = 5;
    localparam int EN_TIME     = 6;

    // First-failed codes
    localparam logic [2:0] FAIL_NONE     = 3'd0;
    localparam logic [2:0] FAIL_SRC_ADDR = 3'd1;
    localparam logic [2:0] FAIL_SRC_PORT = 3'd2;
    localparam logic [2:0] FAIL_DST_ADDR = 3'd3;
    localparam logic [2:0] FAIL_DST_PORT = 3'd4;
    localparam logic [2:0] FAIL_ACTION   = 3'd5;
    localparam logic [2:0] FAIL_HOOK     = 3'd6;
    localparam logic [2:0] FAIL_TIME     = 3'd7;

    // Configuration register indexes
    localparam logic [2:0] CFG_PROTO_MODE    = 3'd0;
    localparam logic [2:0] CFG_CHECK_ENABLES = 3'd1;
    localparam logic [2:0] CFG_ACTION_WANTED = 3'd2;
    localparam logic [2:0] CFG_HOOK_WANTED   = 3'd3;
    localparam logic [2:0] CFG_TIME_START    = 3'd4;
    localparam logic [2:0] CFG_TIME_END      = 3'd5;

    localparam int ADDR_W = 32;
    localparam int TS_W   = 48;
    localparam logic [TS_W-1:0] TIME_END_RST = '1;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [2:0]        entry_index;
        logic              entry_used;
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic [5:0]        prefix_len;
        logic [15:0]       src_port;
        logic [15:0]       dst_port;
        logic [1:0]        action_code;
        logic [1:0]        hook_code;
        logic [TS_W-1:0]   timestamp_ms;
    } req_t;

    typedef struct packed {
        logic       matched;
        logic [2:0] first_failed;
    } rsp_t;

    // Match state gathered as a request walks the chain
    typedef struct packed {
        logic src_any;
        logic src_hit;
        logic dst_any;
        logic dst_hit;
        logic sp_any;
        logic sp_hit;
        logic dp_any;
        logic dp_hit;
    } match_flags_t;

    // Mask of the leading prefix bits; lengths above 32 count as 32
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [5:0] len);
        logic [5:0]        clen;
        logic [ADDR_W-1:0] m;
        clen = (len > 6'(ADDR_W)) ? 6'(ADDR_W) : len;
        for (int b = 0; b < ADDR_W; b++)
        begin
            m[b] = (6'(ADDR_W - b) <= clen);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cplc_cell.sv -----
// One classifier cell: holds one entry of each of the four tables and one
// pipeline stage of the request chain. Depends on cplc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cplc_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   up_valid,
    input  cplc_pkg::req_t        up_item,
    input  cplc_pkg::match_flags_t up_flags,
    output logic                  up_ready,
    output logic                  dn_valid,
    output cplc_pkg::req_t        dn_item,
    output cplc_pkg::match_flags_t dn_flags,
    input  wire                   dn_ready
);
    import cplc_pkg::*;

    // Table entries held by this cell
    logic [ADDR_W-1:0] src_net_reg, src_mask_reg;
    logic [ADDR_W-1:0] dst_net_reg, dst_mask_reg;
    logic [15:0]       sr_low_reg, sr_high_reg, dr_low_reg, dr_high_reg;
    logic              src_used_reg, dst_used_reg, sr_used_reg, dr_used_reg;

    // Stage registers
    logic         valid_reg, valid_next;
    req_t         item_reg;
    match_flags_t flags_reg, flags_next;

    logic take, here;
    logic src_hit_c, dst_hit_c, sp_hit_c, dp_hit_c;

    assign up_ready = !valid_reg || dn_ready;
    assign take     = up_valid && up_ready;
    assign here     = (32'(up_item.entry_index) == CELL_IDX);

    // Compare the incoming request against this cell's entries
    always_comb
    begin
        src_hit_c = src_used_reg &&
                    (((up_item.src_addr ^ src_net_reg) & src_mask_reg) == '0);
        dst_hit_c = dst_used_reg &&
                    (((up_item.dst_addr ^ dst_net_reg) & dst_mask_reg) == '0);
        sp_hit_c  = sr_used_reg && (up_item.src_port >= sr_low_reg) &&
                    (up_item.src_port <= sr_high_reg);
        dp_hit_c  = dr_used_reg && (up_item.dst_port >= dr_low_reg) &&
                    (up_item.dst_port <= dr_high_reg);
        flags_next.src_any = up_flags.src_any || src_used_reg;
        flags_next.src_hit = up_flags.src_hit || src_hit_c;
        flags_next.dst_any = up_flags.dst_any || dst_used_reg;
        flags_next.dst_hit = up_flags.dst_hit || dst_hit_c;
        flags_next.sp_any  = up_flags.sp_any || sr_used_reg;
        flags_next.sp_hit  = up_flags.sp_hit || sp_hit_c;
        flags_next.dp_any  = up_flags.dp_any || dr_used_reg;
        flags_next.dp_hit  = up_flags.dp_hit || dp_hit_c;
    end

    // Advance or drain the stage
    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (dn_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            src_used_reg <= 1'b0;
            dst_used_reg <= 1'b0;
            sr_used_reg  <= 1'b0;
            dr_used_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (take && here)
            begin
                case (up_item.req_type)
                    REQ_LOAD_SRC_PFX: src_used_reg <= up_item.entry_used;
                    REQ_LOAD_DST_PFX: dst_used_reg <= up_item.entry_used;
                    REQ_LOAD_SRC_RNG: sr_used_reg  <= up_item.entry_used;
                    REQ_LOAD_DST_RNG: dr_used_reg  <= up_item.entry_used;
                    default: ;
                endcase
            end
        end
    end

    // Capture the request and write entry values on a matching load
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg  <= up_item;
            flags_reg <= flags_next;
            if (here)
            begin
                case (up_item.req_type)
                    REQ_LOAD_SRC_PFX:
                    begin
                        src_net_reg  <= up_item.src_addr;
                        src_mask_reg <= prefix_mask(up_item.prefix_len);
                    end
                    REQ_LOAD_DST_PFX:
                    begin
                        dst_net_reg  <= up_item.src_addr;
                        dst_mask_reg <= prefix_mask(up_item.prefix_len);
                    end
                    REQ_LOAD_SRC_RNG:
                    begin
                        sr_low_reg  <= up_item.src_port;
                        sr_high_reg <= up_item.dst_port;
                    end
                    REQ_LOAD_DST_RNG:
                    begin
                        dr_low_reg  <= up_item.src_port;
                        dr_high_reg <= up_item.dst_port;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;
    assign dn_flags = flags_reg;

endmodule

`default_nettype wire

// ----- rtl/core/cidr_port_range_log_classifier_top.sv -----
// Top level of the log record classifier: configuration registers, the
// chain of cplc_cell instances and the result register. Depends on cplc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Requests enter on in_valid/in_stall/in_data; a request is taken at a
//   clock edge with in_valid high and in_stall low. Load requests write one
//   entry of a table and give no result; classify requests give exactly one
//   result on out_valid/out_stall/out_data, in request order. Unused request
//   types pass through and give nothing.
//   Each request walks a row of ENTRIES cells, each a pipeline stage
//   holding one entry of every table, then lands in the result register.
//   One request is taken every cycle while in_stall is low.
//   When out_stall holds a result, the stages behind it keep filling bubbles
//   until the row is full, then in_stall rises.
//   The user must write configuration registers through cfg_we/cfg_index/
//   cfg_data only while no request is in flight; the block does not enforce it.
//   Reset clears all table entries to unused, empties the row and loads the
//   register defaults (time_end all ones, everything else zero).
module cidr_port_range_log_classifier_top #(
    parameter int ENTRIES = 8
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_stall,
    input  cplc_pkg::req_t          in_data,
    output logic                    out_valid,
    input  wire                     out_stall,
    output cplc_pkg::rsp_t          out_data,
    input  wire                     cfg_we,
    input  wire [2:0]               cfg_index,
    input  wire [cplc_pkg::TS_W-1:0] cfg_data
);
    import cplc_pkg::*;

    logic [1:0]      proto_mode_reg;
    logic [6:0]      check_en_reg;
    logic [1:0]      action_wanted_reg;
    logic [1:0]      hook_wanted_reg;
    logic [TS_W-1:0] time_start_reg;
    logic [TS_W-1:0] time_end_reg;

    logic         ch_valid [ENTRIES+1];
    req_t         ch_item  [ENTRIES+1];
    match_flags_t ch_flags [ENTRIES+1];
    logic         ch_ready [ENTRIES+1];

    logic         out_valid_reg, out_valid_next;
    rsp_t         out_data_reg, rsp_c;
    logic         last_take, is_cls;
    logic         ports, p_sa, p_sp, p_da, p_dp, p_act, p_hook, p_time;
    match_flags_t fl;
    req_t         it;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proto_mode_reg    <= '0;
            check_en_reg      <= '0;
            action_wanted_reg <= '0;
            hook_wanted_reg   <= '0;
            time_start_reg    <= '0;
            time_end_reg      <= TIME_END_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PROTO_MODE:    proto_mode_reg    <= cfg_data[1:0];
                CFG_CHECK_ENABLES: check_en_reg      <= cfg_data[6:0];
                CFG_ACTION_WANTED: action_wanted_reg <= cfg_data[1:0];
                CFG_HOOK_WANTED:   hook_wanted_reg   <= cfg_data[1:0];
                CFG_TIME_START:    time_start_reg    <= cfg_data;
                CFG_TIME_END:      time_end_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Feed the head of the chain
    assign ch_valid[0] = in_valid;
    assign ch_item[0]  = in_data;
    assign ch_flags[0] = '0;
    assign in_stall    = !ch_ready[0];

    // Row of cells
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        cplc_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (ch_valid[g]),
            .up_item  (ch_item[g]),
            .up_flags (ch_flags[g]),
            .up_ready (ch_ready[g]),
            .dn_valid (ch_valid[g+1]),
            .dn_item  (ch_item[g+1]),
            .dn_flags (ch_flags[g+1]),
            .dn_ready (ch_ready[g+1])
        );
    end

    assign ch_ready[ENTRIES] = !out_valid_reg || !out_stall;
    assign last_take = ch_valid[ENTRIES] && ch_ready[ENTRIES];
    assign it        = ch_item[ENTRIES];
    assign fl        = ch_flags[ENTRIES];
    assign is_cls    = (it.req_type == REQ_CLASSIFY);

    // Resolve the criteria in priority order
    always_comb
    begin
        ports  = (proto_mode_reg != PROTO_ICMP);
        p_sa   = !check_en_reg[EN_SRC_ADDR] || !fl.src_any || fl.src_hit;
        p_sp   = !ports || !check_en_reg[EN_SRC_PORT] || !fl.sp_any || fl.sp_hit;
        p_da   = !check_en_reg[EN_DST_ADDR] || !fl.dst_any || fl.dst_hit;
        p_dp   = !ports || !check_en_reg[EN_DST_PORT] || !fl.dp_any || fl.dp_hit;
        p_act  = !check_en_reg[EN_ACTION] || (it.action_code == action_wanted_reg);
        p_hook = !check_en_reg[EN_HOOK] || (it.hook_code == hook_wanted_reg);
        p_time = !check_en_reg[EN_TIME] ||
                 ((it.timestamp_ms >= time_start_reg) && (it.timestamp_ms <= time_end_reg));

        if (proto_mode_reg == PROTO_RSVD)
            rsp_c.first_failed = FAIL_NONE;
        else if (!p_sa)
            rsp_c.first_failed = FAIL_SRC_ADDR;
        else if (!p_sp)
            rsp_c.first_failed = FAIL_SRC_PORT;
        else if (!p_da)
            rsp_c.first_failed = FAIL_DST_ADDR;
        else if (!p_dp)
            rsp_c.first_failed = FAIL_DST_PORT;
        else if (!p_act)
            rsp_c.first_failed = FAIL_ACTION;
        else if (!p_hook)
            rsp_c.first_failed = FAIL_HOOK;
        else if (!p_time)
            rsp_c.first_failed = FAIL_TIME;
        else
            rsp_c.first_failed = FAIL_NONE;

        rsp_c.matched = (proto_mode_reg != PROTO_RSVD) &&
                        (rsp_c.first_failed == FAIL_NONE);
    end

    // Hold the result until taken; drop non-classify requests
    always_comb
    begin
        if (last_take && is_cls)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (last_take && is_cls)
            out_data_reg <= rsp_c;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- tb/cplc_verdict_checker.sv -----
// Checker for the log record classifier: watches the request, result and
// register ports, predicts each classify verdict and compares. Uses cplc_pkg.
`timescale 1ns / 1ps

module cplc_verdict_checker #(
    parameter int ENTRIES = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  cplc_pkg::req_t        in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  cplc_pkg::rsp_t        out_data,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [cplc_pkg::TS_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);
    import cplc_pkg::*;

    localparam int SIDE_SRC = 0;
    localparam int SIDE_DST = 1;

    // Shadow registers
    logic [1:0]      mode_q;
    logic [6:0]      enables_q;
    logic [1:0]      action_q;
    logic [1:0]      hook_q;
    logic [TS_W-1:0] window_lo_q;
    logic [TS_W-1:0] window_hi_q;

    // Shadow tables, row 0 source, row 1 destination
    logic [31:0] net_addr [2][ENTRIES];
    logic [5:0]  net_len  [2][ENTRIES];
    logic        net_used [2][ENTRIES];
    logic [15:0] rng_lo   [2][ENTRIES];
    logic [15:0] rng_hi   [2][ENTRIES];
    logic        rng_used [2][ENTRIES];

    rsp_t expected_verdicts [$];
    int   mismatches;

    // Pass when no entry is in use or some used prefix covers the address
    function automatic logic prefix_ok(input int side, input logic [31:0] addr);
        logic       any_used;
        logic       hit;
        logic [5:0] len;
        logic [31:0] mask;
        any_used = 1'b0;
        hit = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (net_used[side][i])
            begin
                any_used = 1'b1;
                len = (net_len[side][i] > 6'd32) ? 6'd32 : net_len[side][i];
                mask = (len == 6'd0) ? 32'h0 : (32'hFFFF_FFFF << (6'd32 - len));
                if (((addr ^ net_addr[side][i]) & mask) == 32'h0)
                    hit = 1'b1;
            end
        end
        return hit || !any_used;
    endfunction

    // Pass when no range is in use or some used range holds the port
    function automatic logic range_ok(input int side, input logic [15:0] port);
        logic any_used;
        logic hit;
        any_used = 1'b0;
        hit = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (rng_used[side][i])
            begin
                any_used = 1'b1;
                if (port >= rng_lo[side][i] && port <= rng_hi[side][i])
                    hit = 1'b1;
            end
        end
        return hit || !any_used;
    endfunction

    // Walk the criteria in order and blame the first that fails
    function automatic rsp_t judge_record(input req_t r);
        rsp_t       v;
        logic       ports;
        logic [2:0] fail;
        fail = FAIL_NONE;
        ports = (mode_q != PROTO_ICMP);
        if (enables_q[EN_SRC_ADDR] && !prefix_ok(SIDE_SRC, r.src_addr))
            fail = FAIL_SRC_ADDR;
        else if (ports && enables_q[EN_SRC_PORT] && !range_ok(SIDE_SRC, r.src_port))
            fail = FAIL_SRC_PORT;
        else if (enables_q[EN_DST_ADDR] && !prefix_ok(SIDE_DST, r.dst_addr))
            fail = FAIL_DST_ADDR;
        else if (ports && enables_q[EN_DST_PORT] && !range_ok(SIDE_DST, r.dst_port))
            fail = FAIL_DST_PORT;
        else if (enables_q[EN_ACTION] && r.action_code != action_q)
            fail = FAIL_ACTION;
        else if (enables_q[EN_HOOK] && r.hook_code != hook_q)
            fail = FAIL_HOOK;
        else if (enables_q[EN_TIME] &&
                 (r.timestamp_ms < window_lo_q || r.timestamp_ms > window_hi_q))
            fail = FAIL_TIME;
        v.matched = (fail == FAIL_NONE);
        v.first_failed = fail;
        // reserved mode rejects every record without blaming a criterion
        if (mode_q == PROTO_RSVD)
        begin
            v.matched = 1'b0;
            v.first_failed = FAIL_NONE;
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            mode_q <= '0;
            enables_q <= '0;
            action_q <= '0;
            hook_q <= '0;
            window_lo_q <= '0;
            window_hi_q <= TIME_END_RST;
            for (int s = 0; s < 2; s++)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    net_addr[s][i] <= '0;
                    net_len[s][i] <= '0;
                    net_used[s][i] <= 1'b0;
                    rng_lo[s][i] <= '0;
                    rng_hi[s][i] <= '0;
                    rng_used[s][i] <= 1'b0;
                end
            end
            expected_verdicts.delete();
            mismatches = 0;
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            // Mirror register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PROTO_MODE:    mode_q <= cfg_data[1:0];
                    CFG_CHECK_ENABLES: enables_q <= cfg_data[6:0];
                    CFG_ACTION_WANTED: action_q <= cfg_data[1:0];
                    CFG_HOOK_WANTED:   hook_q <= cfg_data[1:0];
                    CFG_TIME_START:    window_lo_q <= cfg_data;
                    CFG_TIME_END:      window_hi_q <= cfg_data;
                    default: ;
                endcase
            end

            // Compare an accepted result with the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result matched=%0d first_failed=%0d, none expected",
                             $time, out_data.matched, out_data.first_failed);
                    mismatches++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (out_data.matched !== want.matched)
                    begin
                        $display("%0t: matched mismatch: expected %0d actual %0d",
                                 $time, want.matched, out_data.matched);
                        mismatches++;
                    end
                    if (out_data.first_failed !== want.first_failed)
                    begin
                        $display("%0t: first_failed mismatch: expected %0d actual %0d",
                                 $time, want.first_failed, out_data.first_failed);
                        mismatches++;
                    end
                end
            end

            // Apply an accepted request: loads write a table, classify predicts
            if (in_valid && !in_stall)
            begin
                case (in_data.req_type)
                    REQ_LOAD_SRC_PFX, REQ_LOAD_DST_PFX:
                    begin
                        if (in_data.entry_index < ENTRIES)
                        begin
                            net_addr[in_data.req_type == REQ_LOAD_DST_PFX]
                                    [in_data.entry_index] <= in_data.src_addr;
                            net_len[in_data.req_type == REQ_LOAD_DST_PFX]
                                   [in_data.entry_index] <= in_data.prefix_len;
                            net_used[in_data.req_type == REQ_LOAD_DST_PFX]
                                    [in_data.entry_index] <= in_data.entry_used;
                        end
                    end
                    REQ_LOAD_SRC_RNG, REQ_LOAD_DST_RNG:
                    begin
                        if (in_data.entry_index < ENTRIES)
                        begin
                            rng_lo[in_data.req_type == REQ_LOAD_DST_RNG]
                                  [in_data.entry_index] <= in_data.src_port;
                            rng_hi[in_data.req_type == REQ_LOAD_DST_RNG]
                                  [in_data.entry_index] <= in_data.dst_port;
                            rng_used[in_data.req_type == REQ_LOAD_DST_RNG]
                                    [in_data.entry_index] <= in_data.entry_used;
                        end
                    end
                    REQ_CLASSIFY: expected_verdicts.push_back(judge_record(in_data));
                    default: ;
                endcase
            end

            pending <= expected_verdicts.size();
            errors <= mismatches;
        end
    end

endmodule

// ----- tb/cidr_port_range_log_classifier_top_tb.sv -----
// Testbench top for the log record classifier: clock, reset, request and
// register stimulus, result stalls and the verdict. Uses cplc_pkg and
// cplc_verdict_checker.
`timescale 1ns / 1ps

module cidr_port_range_log_classifier_top_tb;
    import cplc_pkg::*;

    localparam int ENTRIES  = 8;
    localparam int LAT      = ENTRIES + 1;
    localparam int LIMIT    = 400000;
    localparam int SIDE_SRC = 0;
    localparam int SIDE_DST = 1;

    localparam logic [1:0] PROTO_TCP = 2'd0;
    localparam logic [1:0] PROTO_UDP = 2'd1;
    localparam logic [6:0] EN_NONE   = '0;
    localparam logic [6:0] EN_ALL    = '1;
    localparam logic [2:0] REQ_FIRST_UNUSED = REQ_CLASSIFY + 3'd1;
    localparam logic [2:0] REQ_LAST_UNUSED  = 3'd7;
    localparam logic [TS_W-1:0] TS_MAX = TIME_END_RST;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    req_t            in_data;
    logic            out_valid;
    logic            out_stall;
    rsp_t            out_data;
    logic            cfg_we;
    logic [2:0]      cfg_index;
    logic [TS_W-1:0] cfg_data;

    int mismatches;
    int pending;
    int cycle_cnt;
    int idle_pct;
    int stall_pct;

    // Current register values, used to steer records toward the edges
    logic [1:0]      cur_act;
    logic [1:0]      cur_hook;
    logic [TS_W-1:0] cur_ts;
    logic [TS_W-1:0] cur_te;

    // Last loaded table contents, also only for steering
    logic [31:0] sh_net [2][ENTRIES];
    logic [5:0]  sh_len [2][ENTRIES];
    logic [15:0] sh_lo  [2][ENTRIES];
    logic [15:0] sh_hi  [2][ENTRIES];

    cidr_port_range_log_classifier_top #(
        .ENTRIES(ENTRIES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    cplc_verdict_checker #(
        .ENTRIES(ENTRIES)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .errors(mismatches),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result side at the current rate
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
        end
    end

    // End the run if it hangs
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [TS_W-1:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic req_t rand_req();
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return raw[$bits(req_t)-1:0];
    endfunction

    function automatic req_t mk_load(input logic [2:0] kind, input logic [2:0] idx,
                                     input logic used, input logic [31:0] net,
                                     input logic [5:0] plen, input logic [15:0] lo,
                                     input logic [15:0] hi);
        req_t r;
        r = '0;
        r.req_type = kind;
        r.entry_index = idx;
        r.entry_used = used;
        r.src_addr = net;
        r.prefix_len = plen;
        r.src_port = lo;
        r.dst_port = hi;
        return r;
    endfunction

    function automatic req_t mk_record(input logic [31:0] sa, input logic [31:0] da,
                                       input logic [15:0] sp, input logic [15:0] dp,
                                       input logic [1:0] act, input logic [1:0] hook,
                                       input logic [TS_W-1:0] ts);
        req_t r;
        r = '0;
        r.req_type = REQ_CLASSIFY;
        r.src_addr = sa;
        r.dst_addr = da;
        r.src_port = sp;
        r.dst_port = dp;
        r.action_code = act;
        r.hook_code = hook;
        r.timestamp_ms = ts;
        return r;
    endfunction

    // Address inside a loaded prefix, or anywhere
    function automatic logic [31:0] near_addr(input int side);
        int          j;
        logic [5:0]  len;
        logic [31:0] a;
        j = $urandom_range(0, ENTRIES - 1);
        len = (sh_len[side][j] > 6'd32) ? 6'd32 : sh_len[side][j];
        a = sh_net[side][j] ^ ($urandom >> len);
        if ($urandom_range(0, 3) == 0)
            a = $urandom;
        return a;
    endfunction

    // Port at, inside or just outside a loaded range
    function automatic logic [15:0] near_port(input int side);
        int          j;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] p;
        j = $urandom_range(0, ENTRIES - 1);
        lo = sh_lo[side][j];
        hi = sh_hi[side][j];
        case ($urandom_range(0, 5))
            0: p = lo;
            1: p = hi;
            2: p = lo - 16'd1;
            3: p = hi + 16'd1;
            4: p = (lo <= hi) ? lo + 16'($urandom_range(0, 32'(hi - lo))) : lo;
            default: p = 16'($urandom);
        endcase
        return p;
    endfunction

    // Timestamp at, inside or just outside the window
    function automatic logic [TS_W-1:0] near_time();
        logic [TS_W-1:0] t;
        logic [63:0]     span;
        case ($urandom_range(0, 5))
            0: t = cur_ts;
            1: t = cur_te;
            2: t = cur_ts - 1'b1;
            3: t = cur_te + 1'b1;
            4:
            begin
                span = 64'(cur_te) - 64'(cur_ts) + 64'd1;
                if (cur_ts <= cur_te)
                    t = cur_ts + TS_W'({$urandom, $urandom} % span);
                else
                    t = rand48();
            end
            default: t = rand48();
        endcase
        return t;
    endfunction

    // Present one request after a random gap and hold it until taken
    task automatic send_req(input req_t r);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        case (r.req_type)
            REQ_LOAD_SRC_PFX, REQ_LOAD_DST_PFX:
            begin
                sh_net[r.req_type == REQ_LOAD_DST_PFX][r.entry_index] = r.src_addr;
                sh_len[r.req_type == REQ_LOAD_DST_PFX][r.entry_index] = r.prefix_len;
            end
            REQ_LOAD_SRC_RNG, REQ_LOAD_DST_RNG:
            begin
                sh_lo[r.req_type == REQ_LOAD_DST_RNG][r.entry_index] = r.src_port;
                sh_hi[r.req_type == REQ_LOAD_DST_RNG][r.entry_index] = r.dst_port;
            end
            default: ;
        endcase
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop sending, wait for every verdict, then let loads clear the row
    task automatic drain_requests();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LAT + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [TS_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Write all six registers while the block is idle
    task automatic program_config(input logic [1:0] pm, input logic [6:0] en,
                                  input logic [1:0] act, input logic [1:0] hook,
                                  input logic [TS_W-1:0] ts, input logic [TS_W-1:0] te);
        drain_requests();
        write_reg(CFG_PROTO_MODE, TS_W'(pm));
        write_reg(CFG_CHECK_ENABLES, TS_W'(en));
        write_reg(CFG_ACTION_WANTED, TS_W'(act));
        write_reg(CFG_HOOK_WANTED, TS_W'(hook));
        write_reg(CFG_TIME_START, ts);
        write_reg(CFG_TIME_END, te);
        cfg_we <= 1'b0;
        cur_act = act;
        cur_hook = hook;
        cur_ts = ts;
        cur_te = te;
    endtask

    // Mostly steered classify requests, some loads, a little ignored noise
    task automatic run_random(input int n);
        int   made;
        int   sel;
        int   span;
        int   hi_i;
        req_t r;
        made = 0;
        while (made < n)
        begin
            sel = $urandom_range(0, 99);
            r = rand_req();
            if (sel < 4)
            begin
                r.req_type = REQ_FIRST_UNUSED + 3'($urandom_range(0, 2));
            end
            else if (sel < 28)
            begin
                r.req_type = 3'($urandom_range(REQ_LOAD_SRC_PFX, REQ_LOAD_DST_RNG));
                r.entry_used = ($urandom_range(0, 99) < 85);
                sel = $urandom_range(0, 99);
                if (sel < 10)
                    r.prefix_len = 6'($urandom_range(33, 63));
                else if (sel < 15)
                    r.prefix_len = '0;
                else
                    r.prefix_len = 6'($urandom_range(8, 32));
                if ($urandom_range(0, 9) != 0)
                begin
                    span = $urandom_range(0, 4000);
                    hi_i = int'(r.src_port) + span;
                    r.dst_port = (hi_i > 65535) ? 16'hFFFF : 16'(hi_i);
                end
                made++;
            end
            else
            begin
                r.req_type = REQ_CLASSIFY;
                if ($urandom_range(0, 9) < 8)
                    r.src_addr = near_addr(SIDE_SRC);
                if ($urandom_range(0, 9) < 8)
                    r.dst_addr = near_addr(SIDE_DST);
                if ($urandom_range(0, 9) < 8)
                    r.src_port = near_port(SIDE_SRC);
                if ($urandom_range(0, 9) < 8)
                    r.dst_port = near_port(SIDE_DST);
                if ($urandom_range(0, 3) != 0)
                    r.action_code = cur_act;
                if ($urandom_range(0, 3) != 0)
                    r.hook_code = cur_hook;
                r.timestamp_ms = near_time();
                made++;
            end
            send_req(r);
        end
    endtask

    initial
    begin
        req_t            good;
        req_t            r;
        logic [TS_W-1:0] wa;
        logic [TS_W-1:0] wb;

        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                sh_net[s][i] = '0;
                sh_len[s][i] = '0;
                sh_lo[s][i] = '0;
                sh_hi[s][i] = '0;
            end
        end
        cur_act = '0;
        cur_hook = '0;
        cur_ts = '0;
        cur_te = TS_MAX;
        idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: nothing enabled, so every record matches
        send_req('0);
        r = '1;
        r.req_type = REQ_CLASSIFY;
        send_req(r);

        // Fill the tables, including an over-long prefix, a cleared entry
        // and an inverted range
        send_req(mk_load(REQ_LOAD_SRC_PFX, 3'd0, 1'b1, 32'h0A00_0000, 6'd8, '0, '0));
        send_req(mk_load(REQ_LOAD_SRC_PFX, 3'd1, 1'b1, 32'hC0A8_0101, 6'd40, '0, '0));
        send_req(mk_load(REQ_LOAD_SRC_PFX, 3'd2, 1'b0, 32'h1234_5678, 6'd16, '0, '0));
        send_req(mk_load(REQ_LOAD_DST_PFX, 3'd7, 1'b1, 32'hAC10_0000, 6'd12, '0, '0));
        send_req(mk_load(REQ_LOAD_SRC_RNG, 3'd0, 1'b1, '0, '0, 16'd1000, 16'd2000));
        send_req(mk_load(REQ_LOAD_SRC_RNG, 3'd6, 1'b1, '0, '0, 16'hFFFF, 16'hFFFF));
        send_req(mk_load(REQ_LOAD_DST_RNG, 3'd3, 1'b1, '0, '0, 16'd500, 16'd100));
        send_req(mk_load(REQ_LOAD_DST_RNG, 3'd4, 1'b1, '0, '0, 16'd80, 16'd80));
        r = rand_req();
        r.req_type = REQ_FIRST_UNUSED;
        send_req(r);
        r.req_type = REQ_LAST_UNUSED;
        send_req(r);

        // Every criterion on, window edges inclusive
        program_config(PROTO_TCP, EN_ALL, 2'd2, 2'd1, 48'd1000, 48'd5000);
        good = mk_record(32'h0A0B_0C0D, 32'hAC1F_0001, 16'd1500, 16'd80, 2'd2, 2'd1,
                         48'd1000);
        send_req(good);
        r = good;
        r.timestamp_ms = 48'd5000;
        send_req(r);
        r.timestamp_ms = 48'd5001;
        send_req(r);
        r = good;
        r.src_addr = 32'hC0A8_0101;
        r.src_port = 16'hFFFF;
        send_req(r);
        r.src_addr = 32'hC0A8_0102;
        send_req(r);
        r = good;
        r.src_port = 16'd999;
        send_req(r);
        r = good;
        r.dst_addr = 32'hAD00_0000;
        send_req(r);
        r = good;
        r.dst_port = 16'd90;
        send_req(r);
        r = good;
        r.action_code = 2'd1;
        send_req(r);
        r = good;
        r.hook_code = 2'd0;
        send_req(r);

        // ICMP skips the port checks
        program_config(PROTO_ICMP, EN_ALL, 2'd2, 2'd1, 48'd1000, 48'd5000);
        r = good;
        r.src_port = 16'd999;
        r.dst_port = 16'd90;
        send_req(r);

        // Reserved mode rejects without blame
        program_config(PROTO_RSVD, EN_ALL, 2'd2, 2'd1, 48'd1000, 48'd5000);
        send_req(good);

        // Inverted window, and a match-any destination prefix
        program_config(PROTO_TCP, EN_ALL, 2'd2, 2'd1, 48'd5000, 48'd1000);
        send_req(mk_load(REQ_LOAD_DST_PFX, 3'd0, 1'b1, 32'h0, 6'd0, '0, '0));
        r = good;
        r.dst_addr = 32'hAD00_0000;
        r.timestamp_ms = 48'd3000;
        send_req(r);

        // Random phases across register settings and idle patterns
        for (int p = 0; p < 8; p++)
        begin
            wa = rand48();
            wb = rand48();
            case (p)
                0: program_config(PROTO_TCP, EN_ALL, 2'($urandom), 2'($urandom),
                                  '0, TS_MAX);
                1: program_config(PROTO_UDP, 7'($urandom), 2'($urandom), 2'($urandom),
                                  (wa < wb) ? wa : wb, (wa < wb) ? wb : wa);
                2: program_config(PROTO_ICMP, EN_ALL, 2'($urandom), 2'($urandom),
                                  (wa < wb) ? wa : wb, (wa < wb) ? wb : wa);
                3: program_config(2'($urandom_range(0, 3)), 7'($urandom), 2'($urandom),
                                  2'($urandom), (wa < wb) ? wa : wb, (wa < wb) ? wb : wa);
                4: program_config(PROTO_TCP, EN_NONE, 2'd3, 2'd3, TS_MAX, '0);
                5: program_config(PROTO_UDP, EN_ALL, 2'($urandom), 2'($urandom),
                                  (wa < wb) ? wb : wa, (wa < wb) ? wa : wb);
                6: program_config(PROTO_TCP, EN_ALL, 2'd0, 2'd0, TS_MAX, TS_MAX);
                default: program_config(2'($urandom_range(0, 2)), 7'($urandom),
                                        2'($urandom), 2'($urandom), wa, wb);
            endcase
            case (p % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 59;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 59;
                end
                default:
                begin
                    idle_pct = 14;
                    stall_pct = 14;
                end
            endcase
            run_random(160);
        end

        // Drain and give the verdict
        drain_requests();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
